// ----- hdl/vgob_pkg.sv -----
// shared constants, codes and pipeline stage types for the voxel grid occupancy builder
// no dependencies

package vgob_pkg;

    localparam int COORD_W   = 32;
    localparam int LABEL_W   = 8;
    localparam int MAP_DEPTH = 65536;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int CELL_W    = 31;
    localparam int COUNT_W   = 17;
    localparam int QUO_W     = COUNT_W;
    localparam int LIMIT_W   = CELL_W + COUNT_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int OP_W      = 2;
    localparam int NUM_AXES  = 3;
    localparam int T_W       = 2 * COUNT_W + 1;
    localparam int BKT_W     = ADDR_W + COUNT_W + 1;
    localparam int CFG_AW    = 5;
    localparam int CFG_DW    = 32;

    localparam logic [LABEL_W-1:0] UNSET_LABEL = '0;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MIN_X        = 3'd0;
    localparam logic [2:0] REG_MIN_Y        = 3'd1;
    localparam logic [2:0] REG_MIN_Z        = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE_XY = 3'd3;
    localparam logic [2:0] REG_CELL_SIZE_Z  = 3'd4;
    localparam logic [2:0] REG_CELLS_X      = 3'd5;
    localparam logic [2:0] REG_CELLS_Y      = 3'd6;
    localparam logic [2:0] REG_CELLS_Z      = 3'd7;

    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    op;
        logic [LABEL_W-1:0] label;
        logic [ADDR_W-1:0]  addr;
    } meta_t;

    typedef struct packed {
        meta_t                                meta;
        logic [NUM_AXES-1:0][DIFF_W-1:0]      diff;
    } stage_a_t;

    typedef struct packed {
        meta_t                                meta;
        logic [NUM_AXES-1:0][DIFF_W-1:0]      diff;
        logic [NUM_AXES-1:0][LIMIT_W-1:0]     limit;
    } stage_b_t;

    typedef struct packed {
        meta_t                                meta;
        logic [NUM_AXES-1:0]                  ok;
        logic [NUM_AXES-1:0][COORD_W-1:0]     rem;
        logic [NUM_AXES-1:0][QUO_W-1:0]       quo;
    } stage_div_t;

    typedef struct packed {
        meta_t              meta;
        logic               ok;
        logic [T_W-1:0]     t;
        logic [QUO_W-1:0]   iz;
    } stage_m1_t;

    typedef struct packed {
        meta_t              meta;
        logic               ok;
        logic [BKT_W-1:0]   bkt;
    } stage_m2_t;

    typedef struct packed {
        logic               valid;
        logic               is_read;
        logic               acc;
        logic [ADDR_W-1:0]  idx;
        logic [LABEL_W-1:0] lab;
    } stage_m3_t;

endpackage

// ----- hdl/vgob_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies

module vgob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/voxel_grid_occupancy_builder.sv -----
// top level of the voxel grid occupancy builder: stream ports, register file, pipeline
// depends on vgob_pkg and vgob_ram

// Voxel grid occupancy builder. One beat enters on the s_ group and one result beat
// leaves on the m_ group for each. An insert takes a signed Q15.16 point, subtracts the
// box minimum on each axis, divides by the cell size (floor) and stores the label at
// bucket (ix*cells_y + iy)*cells_z + iz of a 65536 entry label store; points below the
// minimum or past the cell count on any axis, or whose bucket is past the store, are
// rejected. Read returns the label at bucket_address, clear writes the unset code there.
// The block takes one beat every cycle unless the m_ side stalls or the clearing pass
// runs; the pipeline from input to the output register has three setup stages (offset,
// per-axis limit count*cell, range check), 17 restoring divider stages giving one
// quotient bit each, two index multiply stages, the store access stage (ram read data
// registered alongside it) and the output register. The store is only touched in one
// stage, so reads always see every earlier write. A stalled m_ side freezes the whole
// pipeline. After reset a clearing pass writes the unset code into all 65536 entries,
// one per cycle, with s_tready low until it ends; register writes are taken throughout.
// Registers (byte address): min_x 0x00, min_y 0x04, min_z 0x08, cell_size_xy 0x0c,
// cell_size_z 0x10, cells_x 0x14, cells_y 0x18, cells_z 0x1c; write only while idle.

module voxel_grid_occupancy_builder
    import vgob_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input beats
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [119:0]        s_tdata,   // point_x, point_y, point_z, point_label, bucket_address
    input  logic [1:0]          s_tuser,   // operation
    // result beats
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // bucket_index, stored_label
    output logic [0:0]          m_tuser,   // accepted
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready
);

    // configuration registers
    logic signed [COORD_W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic [CELL_W-1:0]         cell_size_xy_reg, cell_size_z_reg;
    logic [COUNT_W-1:0]        cells_x_reg, cells_y_reg, cells_z_reg;

    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg        <= '0;
            min_y_reg        <= '0;
            min_z_reg        <= '0;
            cell_size_xy_reg <= CELL_W'(13107);
            cell_size_z_reg  <= CELL_W'(65536000);
            cells_x_reg      <= COUNT_W'(256);
            cells_y_reg      <= COUNT_W'(256);
            cells_z_reg      <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                REG_MIN_X:        min_x_reg        <= pwdata;
                REG_MIN_Y:        min_y_reg        <= pwdata;
                REG_MIN_Z:        min_z_reg        <= pwdata;
                REG_CELL_SIZE_XY: cell_size_xy_reg <= pwdata[CELL_W-1:0];
                REG_CELL_SIZE_Z:  cell_size_z_reg  <= pwdata[CELL_W-1:0];
                REG_CELLS_X:      cells_x_reg      <= pwdata[COUNT_W-1:0];
                REG_CELLS_Y:      cells_y_reg      <= pwdata[COUNT_W-1:0];
                REG_CELLS_Z:      cells_z_reg      <= pwdata[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MIN_X:        prdata = min_x_reg;
            REG_MIN_Y:        prdata = min_y_reg;
            REG_MIN_Z:        prdata = min_z_reg;
            REG_CELL_SIZE_XY: prdata = CFG_DW'(cell_size_xy_reg);
            REG_CELL_SIZE_Z:  prdata = CFG_DW'(cell_size_z_reg);
            REG_CELLS_X:      prdata = CFG_DW'(cells_x_reg);
            REG_CELLS_Y:      prdata = CFG_DW'(cells_y_reg);
            REG_CELLS_Z:      prdata = CFG_DW'(cells_z_reg);
            default:          prdata = '0;
        endcase
    end

    // per-axis views of the configuration
    logic [NUM_AXES-1:0][COORD_W-1:0] min_of;
    logic [NUM_AXES-1:0][CELL_W-1:0]  cell_of;
    logic [NUM_AXES-1:0][COUNT_W-1:0] count_of;

    assign min_of   = {min_z_reg, min_y_reg, min_x_reg};
    assign cell_of  = {cell_size_z_reg, cell_size_xy_reg, cell_size_xy_reg};
    assign count_of = {cells_z_reg, cells_y_reg, cells_x_reg};

    // clearing pass after reset
    logic [ADDR_W:0] init_cnt_reg;
    logic            init_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg  <= '0;
            init_done_reg <= 1'b0;
        end
        else if (!init_done_reg)
        begin
            init_cnt_reg <= init_cnt_reg + 1'b1;
            if (init_cnt_reg == (ADDR_W + 1)'(MAP_DEPTH - 1))
            begin
                init_done_reg <= 1'b1;
            end
        end
    end

    // whole pipeline moves when the output register is free or drained
    logic out_valid_reg;
    logic adv;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && init_done_reg;

    // stage a: offsets from the box minimum
    stage_a_t a_reg, a_next;
    logic [NUM_AXES-1:0][COORD_W-1:0] point_of;
    assign point_of = {s_tdata[95:64], s_tdata[63:32], s_tdata[31:0]};

    always_comb
    begin
        a_next.meta.valid = s_tvalid && init_done_reg;
        a_next.meta.op    = s_tuser;
        a_next.meta.label = s_tdata[103:96];
        a_next.meta.addr  = s_tdata[119:104];
        for (int a = 0; a < NUM_AXES; a++)
        begin
            a_next.diff[a] = {point_of[a][COORD_W-1], point_of[a]}
                           - {min_of[a][COORD_W-1], min_of[a]};
        end
    end

    // stage b: upper bound count*cell per axis
    stage_b_t b_reg, b_next;
    always_comb
    begin
        b_next.meta = a_reg.meta;
        b_next.diff = a_reg.diff;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            b_next.limit[a] = LIMIT_W'(count_of[a]) * LIMIT_W'(cell_of[a]);
        end
    end

    // divider entry: range check, quotient then fits in QUO_W bits
    stage_div_t div_reg [QUO_W+1];
    stage_div_t div0_next;
    always_comb
    begin
        div0_next.meta = b_reg.meta;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            div0_next.ok[a]  = !b_reg.diff[a][DIFF_W-1]
                            && (LIMIT_W'(b_reg.diff[a][COORD_W-1:0]) < b_reg.limit[a]);
            div0_next.rem[a] = b_reg.diff[a][COORD_W-1:0];
            div0_next.quo[a] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg      <= '0;
            b_reg      <= '0;
            div_reg[0] <= '0;
        end
        else if (adv)
        begin
            a_reg      <= a_next;
            b_reg      <= b_next;
            div_reg[0] <= div0_next;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        localparam int SHIFT = QUO_W - 1 - j;
        stage_div_t                       div_next;
        logic [NUM_AXES-1:0][LIMIT_W-1:0] trial;

        always_comb
        begin
            div_next = div_reg[j];
            for (int a = 0; a < NUM_AXES; a++)
            begin
                trial[a] = LIMIT_W'(cell_of[a]) << SHIFT;
                if (LIMIT_W'(div_reg[j].rem[a]) >= trial[a])
                begin
                    div_next.rem[a]        = div_reg[j].rem[a] - trial[a][COORD_W-1:0];
                    div_next.quo[a][SHIFT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_reg[j+1] <= '0;
            end
            else if (adv)
            begin
                div_reg[j+1] <= div_next;
            end
        end
    end

    // bucket arithmetic, one multiply per stage
    stage_m1_t m1_reg, m1_next;
    stage_m2_t m2_reg, m2_next;
    stage_div_t div_last;
    assign div_last = div_reg[QUO_W];

    always_comb
    begin
        m1_next.meta = div_last.meta;
        m1_next.ok   = &div_last.ok;
        m1_next.t    = T_W'(div_last.quo[0]) * T_W'(cells_y_reg) + T_W'(div_last.quo[1]);
        m1_next.iz   = div_last.quo[2];
    end

    // a row index past the store can only grow, since cells_z is at least one here
    always_comb
    begin
        m2_next.meta = m1_reg.meta;
        m2_next.ok   = m1_reg.ok && (m1_reg.t < T_W'(MAP_DEPTH));
        m2_next.bkt  = BKT_W'(m1_reg.t[ADDR_W-1:0]) * BKT_W'(cells_z_reg)
                     + BKT_W'(m1_reg.iz);
    end

    // store access stage
    stage_m3_t          m3_reg, m3_next;
    logic               ins_ok, addr_ok;
    logic               pipe_we;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [LABEL_W-1:0] ram_wdata;
    logic [LABEL_W-1:0] ram_rdata;

    always_comb
    begin
        ins_ok  = m2_reg.ok && (m2_reg.bkt < BKT_W'(MAP_DEPTH));
        addr_ok = (ADDR_W + 1)'(m2_reg.meta.addr) < (ADDR_W + 1)'(MAP_DEPTH);
        m3_next.valid   = m2_reg.meta.valid;
        m3_next.is_read = 1'b0;
        m3_next.acc     = 1'b0;
        m3_next.idx     = '0;
        m3_next.lab     = '0;
        pipe_we         = 1'b0;
        case (m2_reg.meta.op)
            OP_INSERT:
            begin
                if (ins_ok)
                begin
                    m3_next.acc = 1'b1;
                    m3_next.idx = m2_reg.bkt[ADDR_W-1:0];
                    m3_next.lab = m2_reg.meta.label;
                    pipe_we     = 1'b1;
                end
            end
            OP_READ:
            begin
                m3_next.idx     = m2_reg.meta.addr;
                m3_next.acc     = addr_ok;
                m3_next.is_read = addr_ok;
            end
            OP_CLEAR:
            begin
                m3_next.idx = m2_reg.meta.addr;
                m3_next.acc = addr_ok;
                m3_next.lab = UNSET_LABEL;
                pipe_we     = addr_ok;
            end
            default: ;
        endcase
    end

    assign ram_we    = init_done_reg ? (adv && m2_reg.meta.valid && pipe_we) : 1'b1;
    assign ram_waddr = init_done_reg ? m3_next.idx : init_cnt_reg[ADDR_W-1:0];
    assign ram_wdata = init_done_reg ? m3_next.lab : UNSET_LABEL;

    vgob_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (MAP_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (m2_reg.meta.addr),
        .rdata (ram_rdata)
    );

    // output register
    logic               out_acc_reg;
    logic [ADDR_W-1:0]  out_idx_reg;
    logic [LABEL_W-1:0] out_lab_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg        <= '0;
            m2_reg        <= '0;
            m3_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_acc_reg   <= 1'b0;
            out_idx_reg   <= '0;
            out_lab_reg   <= '0;
        end
        else if (adv)
        begin
            m1_reg        <= m1_next;
            m2_reg        <= m2_next;
            m3_reg        <= m3_next;
            out_valid_reg <= m3_reg.valid;
            out_acc_reg   <= m3_reg.acc;
            out_idx_reg   <= m3_reg.idx;
            out_lab_reg   <= m3_reg.is_read ? ram_rdata : m3_reg.lab;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_acc_reg;
    assign m_tdata  = {out_lab_reg, out_idx_reg};

    // checks
    a_no_beat_in_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
        !init_done_reg |-> !s_tready)
        else $error("input taken during clearing pass");

    a_store_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!init_done_reg || m2_reg.meta.valid))
        else $error("store written with no item in the access stage");

    a_access_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv && m2_reg.meta.valid |=> m3_reg.valid)
        else $error("item lost after store access");

    a_read_is_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        m3_reg.valid && m3_reg.is_read |-> m3_reg.acc)
        else $error("read issued for rejected address");

    a_reject_zero_label: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_acc_reg |-> (out_lab_reg == UNSET_LABEL))
        else $error("rejected beat carries a label");

endmodule

// ----- tb/voxel_grid_occupancy_builder_tb.sv -----
// self-checking testbench for the voxel grid occupancy builder: directed table then random beats
// checks every result beat against an in-bench label store and grid predictor
// depends on vgob_pkg and the voxel_grid_occupancy_builder rtl
`timescale 1ns / 1ps

module voxel_grid_occupancy_builder_tb;
    import vgob_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 40;     // pipeline is 24 deep
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off, fills the pipeline

    typedef struct {
        logic               acc;
        logic [ADDR_W-1:0]  idx;
        logic [LABEL_W-1:0] lab;
    } voxel_result_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [31:0]        px;
        logic [31:0]        py;
        logic [31:0]        pz;
        logic [LABEL_W-1:0] lab;
        logic [ADDR_W-1:0]  addr;
        bit                 typed;
        voxel_result_t      res;
    } grid_cmd_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [119:0]       s_tdata;   // point_x, point_y, point_z, point_label, bucket_address
    logic [1:0]         s_tuser;   // operation
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;   // bucket_index, stored_label
    logic [0:0]         m_tuser;   // accepted
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [CFG_DW-1:0]  pwdata;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;

    voxel_grid_occupancy_builder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the register file and the label store
    logic [31:0]        grid_min [3];
    logic [CELL_W-1:0]  cell_xy;
    logic [CELL_W-1:0]  cell_z;
    logic [COUNT_W-1:0] cell_cnt [3];
    logic [LABEL_W-1:0] label_store [MAP_DEPTH];

    voxel_result_t      pending_results [$];
    int                 fail_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 recv_hold;
    logic [ADDR_W-1:0]  last_bucket;
    longint             cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("voxel_grid_occupancy_builder_tb NOT OK");
                $finish;
            end
        end
    end

    // cell index along one axis, -1 when the point falls outside
    function automatic longint axis_index(logic [31:0] p, logic [31:0] mn,
                                          logic [CELL_W-1:0] cell_len, logic [COUNT_W-1:0] cnt);
        longint d;
        longint q;
        d = longint'($signed(p)) - longint'($signed(mn));
        if (d < 0 || cell_len == 0 || cnt == 0)
            return -1;
        q = d / longint'(cell_len);
        if (q >= longint'(cnt))
            return -1;
        return q;
    endfunction

    // expected result of one beat; updates the shadow store
    function automatic voxel_result_t grid_outcome(grid_cmd_t c);
        voxel_result_t r;
        longint ix;
        longint iy;
        longint iz;
        longint bkt;
        r.acc = 1'b0;
        r.idx = '0;
        r.lab = '0;
        if (c.op == OP_INSERT)
        begin
            ix = axis_index(c.px, grid_min[0], cell_xy, cell_cnt[0]);
            iy = axis_index(c.py, grid_min[1], cell_xy, cell_cnt[1]);
            iz = axis_index(c.pz, grid_min[2], cell_z, cell_cnt[2]);
            if (ix >= 0 && iy >= 0 && iz >= 0)
            begin
                bkt = (ix * longint'(cell_cnt[1]) + iy) * longint'(cell_cnt[2]) + iz;
                if (bkt < MAP_DEPTH)
                begin
                    label_store[bkt] = c.lab;
                    r.acc = 1'b1;
                    r.idx = bkt[ADDR_W-1:0];
                    r.lab = c.lab;
                end
            end
        end
        else if (c.op == OP_READ || c.op == OP_CLEAR)
        begin
            // 16-bit address always lies inside the store
            r.idx = c.addr;
            r.acc = 1'b1;
            if (c.op == OP_CLEAR)
                label_store[c.addr] = UNSET_LABEL;
            r.lab = label_store[c.addr];
        end
        return r;
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_AW'(idx) << 2;
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_MIN_X:        grid_min[0] = val;
            REG_MIN_Y:        grid_min[1] = val;
            REG_MIN_Z:        grid_min[2] = val;
            REG_CELL_SIZE_XY: cell_xy     = val[CELL_W-1:0];
            REG_CELL_SIZE_Z:  cell_z      = val[CELL_W-1:0];
            REG_CELLS_X:      cell_cnt[0] = val[COUNT_W-1:0];
            REG_CELLS_Y:      cell_cnt[1] = val[COUNT_W-1:0];
            default:          cell_cnt[2] = val[COUNT_W-1:0];
        endcase
    endtask

    task automatic load_grid(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                             logic [31:0] cxy, logic [31:0] cz,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
        reg_write(REG_MIN_X, mx);
        reg_write(REG_MIN_Y, my);
        reg_write(REG_MIN_Z, mz);
        reg_write(REG_CELL_SIZE_XY, cxy);
        reg_write(REG_CELL_SIZE_Z, cz);
        reg_write(REG_CELLS_X, nx);
        reg_write(REG_CELLS_Y, ny);
        reg_write(REG_CELLS_Z, nz);
    endtask

    // offer one beat, with a random gap first; the expectation is queued on acceptance
    task automatic send_beat(grid_cmd_t c);
        voxel_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = c.op;
        s_tdata  = {c.addr, c.lab, c.pz, c.py, c.px};
        do
            @(posedge clk);
        while (!s_tready);
        r = grid_outcome(c);
        if (r.acc && c.op == OP_INSERT)
            last_bucket = r.idx;
        if (c.typed)
            r = c.res;
        pending_results.insert(pending_results.size(), r);
        @(negedge clk);
    endtask

    // coordinate that lands in a chosen cell of one axis
    function automatic logic [31:0] coord_in_grid(logic [31:0] mn, logic [CELL_W-1:0] cell_len,
                                                  logic [COUNT_W-1:0] cnt);
        longint v;
        v = longint'($signed(mn))
            + longint'($urandom_range(int'(cnt) - 1)) * longint'(cell_len)
            + longint'($urandom_range(int'(cell_len) - 1));
        if (v > 64'sh7fffffff || v < -64'sh80000000)
            return $urandom;
        return v[31:0];
    endfunction

    task automatic random_beats(int n);
        grid_cmd_t c;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick   = $urandom_range(99);
            c.typed = 1'b0;
            c.px   = $urandom;
            c.py   = $urandom;
            c.pz   = $urandom;
            c.lab  = $urandom;
            c.addr = $urandom;
            if (pick < 60)
            begin
                c.op = OP_INSERT;
                c.px = coord_in_grid(grid_min[0], cell_xy, cell_cnt[0]);
                c.py = coord_in_grid(grid_min[1], cell_xy, cell_cnt[1]);
                c.pz = coord_in_grid(grid_min[2], cell_z, cell_cnt[2]);
            end
            else if (pick < 72)
                c.op = OP_INSERT;
            else if (pick < 86)
            begin
                c.op = OP_READ;
                if ($urandom_range(1))
                    c.addr = last_bucket;
            end
            else if (pick < 96)
            begin
                c.op = OP_CLEAR;
                if ($urandom_range(1))
                    c.addr = last_bucket;
            end
            else
                c.op = 2'd3;   // undefined operation, must pass as a reject
            send_beat(c);
        end
        s_tvalid = 1'b0;
    endtask

    task automatic drain;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver: random stalls, plus the long hold-off when asked
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        voxel_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: idx %0d", m_tdata[15:0]);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.acc)
                begin
                    $error("accepted: expected %0d, got %0d", want.acc, m_tuser[0]);
                    fail_count++;
                end
                if (m_tdata[15:0] !== want.idx)
                begin
                    $error("bucket_index: expected %0d, got %0d", want.idx, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[23:16] !== want.lab)
                begin
                    $error("stored_label: expected %0d, got %0d", want.lab, m_tdata[23:16]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        grid_cmd_t table_rows [14];
        grid_cmd_t c;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 1'b0;
        last_bucket    = '0;
        grid_min[0] = 0;
        grid_min[1] = 0;
        grid_min[2] = 0;
        cell_xy     = 13107;
        cell_z      = 65536000;
        cell_cnt[0] = 256;
        cell_cnt[1] = 256;
        cell_cnt[2] = 1;
        for (int i = 0; i < MAP_DEPTH; i++)
            label_store[i] = UNSET_LABEL;

        // reset grid: 256 x 256 x 1 cells of 0.2 units, bucket = ix*256 + iy
        // op, x, y, z, label, address, typed, expected {accepted, index, label}
        table_rows[0]  = '{OP_READ,   0, 0, 0, 8'h00, 16'd0,     1, '{1, 0, 0}};
        table_rows[1]  = '{OP_READ,   0, 0, 0, 8'h00, 16'hffff,  1, '{1, 16'hffff, 0}};
        table_rows[2]  = '{OP_INSERT, 0, 0, 0, 8'hff, 16'd0,     1, '{1, 0, 8'hff}};
        // just below the minimum on each axis
        table_rows[3]  = '{OP_INSERT, 32'hffffffff, 0, 0, 8'h11, 0, 1, '{0, 0, 0}};
        table_rows[4]  = '{OP_INSERT, 0, 32'hffffffff, 0, 8'h22, 0, 1, '{0, 0, 0}};
        table_rows[5]  = '{OP_INSERT, 0, 0, 32'hffffffff, 8'h33, 0, 1, '{0, 0, 0}};
        // last cell of the grid, then one past it on x
        table_rows[6]  = '{OP_INSERT, 3355391, 3355391, 0, 8'ha5, 0, 1, '{1, 16'hffff, 8'ha5}};
        table_rows[7]  = '{OP_INSERT, 3355392, 0, 0, 8'h5a, 0, 1, '{0, 0, 0}};
        table_rows[8]  = '{OP_READ,   0, 0, 0, 8'h00, 16'hffff,  1, '{1, 16'hffff, 8'ha5}};
        table_rows[9]  = '{OP_CLEAR,  0, 0, 0, 8'h00, 16'hffff,  1, '{1, 16'hffff, 0}};
        table_rows[10] = '{2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 8'hff, 16'hffff,
                           1, '{0, 0, 0}};
        // coordinate extremes
        table_rows[11] = '{OP_INSERT, 32'h7fffffff, 0, 0, 8'h01, 0, 1, '{0, 0, 0}};
        table_rows[12] = '{OP_INSERT, 32'h80000000, 0, 0, 8'h02, 0, 1, '{0, 0, 0}};
        table_rows[13] = '{OP_INSERT, 1000000, 2000000, 32'h7fffffff, 8'h77, 0, 0, '{0, 0, 0}};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // the block clears its store first; beats simply wait for s_tready
        foreach (table_rows[i])
            send_beat(table_rows[i]);
        c = table_rows[0];
        c.op = OP_READ;
        c.addr = 16'd0;
        c.typed = 1'b0;
        send_beat(c);
        random_beats(180);
        drain();

        // small dense grid, many overwrites
        load_grid(32'hfff80000, 32'h00010000, 32'hffff8000, 32'h00010000, 32'h00008000,
                  16, 16, 16);
        send_idle_pct = 52;
        random_beats(190);
        drain();

        // register extremes: most buckets run past the store
        load_grid(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  65536, 65536, 65536);
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        random_beats(190);
        drain();

        // one cell of the smallest size (one lsb) at the top corner
        load_grid(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 1, 1, 1, 1);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        random_beats(190);
        drain();

        // long x line, random minimum; receiver holds off so the pipeline backs up
        load_grid($urandom, $urandom, $urandom, 1, $urandom_range(32'h7fffffff, 1),
                  65536, 1, 1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                recv_hold = 1'b0;
            end
        join_none
        random_beats(190);
        drain();

        // random mid-size grid, back to reset values after
        load_grid($urandom_range(65535) - 32768, $urandom_range(65535) - 32768, 0,
                  $urandom_range(1 << 20, 1), $urandom_range(1 << 20, 1),
                  $urandom_range(64, 1), $urandom_range(64, 1), $urandom_range(16, 1));
        send_idle_pct  = 52;
        recv_stall_pct = 52;
        random_beats(110);
        drain();
        load_grid(0, 0, 0, 13107, 65536000, 256, 256, 1);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        random_beats(90);
        drain();

        if (fail_count == 0)
            $display("voxel_grid_occupancy_builder_tb OK");
        else
            $display("voxel_grid_occupancy_builder_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/vgob_pkg.sv
hdl/vgob_ram.sv
hdl/voxel_grid_occupancy_builder.sv
tb/voxel_grid_occupancy_builder_tb.sv
